### design/sols_pkg.sv
// ----------------------------------------------------------------------------
// sols_pkg
// shared types and constants of the self-organizing list search core
// ----------------------------------------------------------------------------
package sols_pkg;

  localparam int KEY_W = 32;
  localparam int HIT_W = 16;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  // item kinds
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // reorder modes
  localparam logic [1:0] MODE_PLAIN     = 2'd0;
  localparam logic [1:0] MODE_FRONT     = 2'd1;
  localparam logic [1:0] MODE_TRANSPOSE = 2'd2;
  localparam logic [1:0] MODE_COUNT     = 2'd3;

  // per-cycle commands broadcast along the row of cells
  typedef struct packed {
    logic load_match;  // capture key compare
    logic move;        // lift hit entry to its target slot
    logic append;      // write key at the tail slot
  } cell_ctl_t;

endpackage

### design/sols_cell.sv
// ----------------------------------------------------------------------------
// sols_cell
// one list slot: key, hit count, match flag and its links in the search chains
// ----------------------------------------------------------------------------
module sols_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic                     clk,
  input  sols_pkg::cell_ctl_t      ctl,
  input  logic [31:0]              key,
  input  logic [CW-1:0]            total,
  input  logic [IW-1:0]            pos,
  input  logic [IW-1:0]            dst,
  input  logic [15:0]              hits_new,
  input  logic [31:0]              prev_key,
  input  logic [15:0]              prev_hits,
  input  logic                     seen_in,
  input  logic [IW-1:0]            pos_in,
  input  logic [15:0]              hsel_in,
  input  logic                     lt_seen_in,
  input  logic [IW-1:0]            dst_in,
  output logic                     seen_out,
  output logic [IW-1:0]            pos_out,
  output logic [15:0]              hsel_out,
  output logic                     lt_seen_out,
  output logic [IW-1:0]            dst_out,
  output logic [31:0]              key_q,
  output logic [15:0]              hits_q
);
  import sols_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_CNT = CW'(IDX);

  logic meq;
  logic active;
  logic first;
  logic lt_cand;
  logic lt_first;

  assign active   = MY_CNT < total;
  assign first    = meq && !seen_in;
  assign lt_cand  = (MY_IDX < pos) && (hits_q < hits_new);
  assign lt_first = lt_cand && !lt_seen_in;

  // first-match chain and first-smaller-count chain
  assign seen_out    = seen_in | meq;
  assign pos_out     = pos_in | (first ? MY_IDX : '0);
  assign hsel_out    = hsel_in | (first ? hits_q : '0);
  assign lt_seen_out = lt_seen_in | lt_cand;
  assign dst_out     = dst_in | (lt_first ? MY_IDX : '0);

  always_ff @(posedge clk) begin
    if (ctl.load_match) begin
      meq <= active && (key_q == key);
    end
    if (ctl.append && (MY_CNT == total)) begin
      key_q  <= key;
      hits_q <= '0;
    end else if (ctl.move) begin
      if (MY_IDX == dst) begin
        key_q  <= key;
        hits_q <= hits_new;
      end else if ((MY_IDX > dst) && (MY_IDX <= pos)) begin
        key_q  <= prev_key;
        hits_q <= prev_hits;
      end
    end
  end

endmodule

### design/self_organizing_list_search_core.sv
// ----------------------------------------------------------------------------
// self_organizing_list_search_core
// ordered key list with append, search and self-organizing reorder
// ----------------------------------------------------------------------------
//
//  channel   direction  payload
//  s_*       in         s_tuser: kind, s_tdata: key
//  m_*       out        m_tuser: hit, rejected; m_tdata: position, hit_count,
//                       occupancy
//  apb       in/out     reorder_mode at byte address 0
//
// each request steps through accept with key compare in every cell, first
// match select, reorder target select, then the move and the result load
// the select steps read the two ripple chains that run through the row of cells
// rst clears the fill count, the sequencer, the result valid and the mode
// a stalled result holds the sequencer in its last step, the next request is
// taken as soon as the result is loaded
// slot contents have no reset, only slots below the fill count take part
//
module self_organizing_list_search_core #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic        s_tuser,   // [0] kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [3:0] position, [19:4] hit_count, [24:20] occupancy
  output logic [1:0]  m_tuser,   // [0] hit, [1] rejected
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sols_pkg::*;

  localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IWX  = IW + 4;
  localparam int CWX  = CW + 5;
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEL  = 4'b0010,
    ST_ORD  = 4'b0100,
    ST_MOVE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [1:0]    reorder_mode;
  logic [CW-1:0] total;
  logic          kind_q;
  logic [31:0]   key_q;
  logic          found;
  logic [IW-1:0] pos;
  logic [15:0]   cnt;
  logic [IW-1:0] dst;

  logic          accept;
  logic          out_free;
  logic          finish;
  cell_ctl_t     ctl;
  logic [31:0]   cell_key;

  // chains through the row of cells
  logic [DEPTH:0]         seen_c;
  logic [DEPTH:0][IW-1:0] pos_c;
  logic [DEPTH:0][15:0]   hsel_c;
  logic [DEPTH:0]         lt_c;
  logic [DEPTH:0][IW-1:0] dst_c;
  logic [DEPTH-1:0][31:0] key_a;
  logic [DEPTH-1:0][15:0] hits_a;

  logic [15:0]   cnt_next;
  logic [IW-1:0] dst_next;
  logic          is_full;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {30'd0, reorder_mode};

  always_ff @(posedge clk) begin
    if (rst) begin
      reorder_mode <= MODE_PLAIN;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      reorder_mode <= pwdata[1:0];
    end
  end

  // handshake
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == ST_MOVE) && out_free;
  assign is_full  = (total == FULL);

  // compare against the incoming key, later writes use the held one
  assign cell_key = (state == ST_IDLE) ? s_tdata : key_q;

  assign ctl.load_match = accept;
  assign ctl.move       = finish && (kind_q == KIND_SEARCH) && found;
  assign ctl.append     = finish && (kind_q == KIND_APPEND) && !is_full;

  assign seen_c[0] = 1'b0;
  assign pos_c[0]  = '0;
  assign hsel_c[0] = '0;
  assign lt_c[0]   = 1'b0;
  assign dst_c[0]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] prev_key;
    logic [15:0] prev_hits;
    if (i == 0) begin : g_head
      assign prev_key  = '0;
      assign prev_hits = '0;
    end else begin : g_body
      assign prev_key  = key_a[i-1];
      assign prev_hits = hits_a[i-1];
    end
    sols_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .key         (cell_key),
      .total       (total),
      .pos         (pos),
      .dst         (dst),
      .hits_new    (cnt),
      .prev_key    (prev_key),
      .prev_hits   (prev_hits),
      .seen_in     (seen_c[i]),
      .pos_in      (pos_c[i]),
      .hsel_in     (hsel_c[i]),
      .lt_seen_in  (lt_c[i]),
      .dst_in      (dst_c[i]),
      .seen_out    (seen_c[i+1]),
      .pos_out     (pos_c[i+1]),
      .hsel_out    (hsel_c[i+1]),
      .lt_seen_out (lt_c[i+1]),
      .dst_out     (dst_c[i+1]),
      .key_q       (key_a[i]),
      .hits_q      (hits_a[i])
    );
  end

  // count after any increment, saturating in frequency mode
  always_comb begin
    cnt_next = hsel_c[DEPTH];
    if ((reorder_mode == MODE_COUNT) && (hsel_c[DEPTH] != HIT_MAX)) begin
      cnt_next = hsel_c[DEPTH] + 16'd1;
    end
  end

  // slot the hit entry ends up in
  always_comb begin
    unique case (reorder_mode)
      MODE_FRONT:     dst_next = '0;
      MODE_TRANSPOSE: dst_next = (pos == '0) ? '0 : pos - IW'(1);
      MODE_COUNT:     dst_next = lt_c[DEPTH] ? dst_c[DEPTH] : pos;
      default:        dst_next = pos;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_SEL;
      ST_SEL:  state_next = ST_ORD;
      ST_ORD:  state_next = ST_MOVE;
      ST_MOVE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= s_tuser;
      key_q  <= s_tdata;
    end
    if (state == ST_SEL) begin
      found <= seen_c[DEPTH];
      pos   <= pos_c[DEPTH];
      cnt   <= cnt_next;
    end
    if (state == ST_ORD) begin
      dst <= dst_next;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.append) begin
      total <= total + CW'(1);
    end
  end

  // result register
  logic [IWX-1:0] pos_wide;
  logic [CWX-1:0] occ_wide;
  logic           res_hit;

  assign res_hit = (kind_q == KIND_SEARCH) && found;

  always_comb begin
    pos_wide = '0;
    occ_wide = CWX'(total);
    if (res_hit) begin
      pos_wide = IWX'(pos);
    end else if (ctl.append) begin
      pos_wide = IWX'(total);
    end
    if (ctl.append) begin
      occ_wide = CWX'(total) + CWX'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {7'd0, occ_wide[4:0], (res_hit ? cnt : 16'd0), pos_wide[3:0]};
      m_tuser <= {(kind_q == KIND_APPEND) && is_full, res_hit};
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    total <= FULL)
    else $error("fill count beyond list depth");

  a_result_from_move: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_MOVE))
    else $error("result raised outside the move step");

  a_hit_not_rejected: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result both hit and rejected");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEL) |-> $past(accept))
    else $error("select step without an accepted request");

endmodule
